// ===== hw/rtl/gmbl_pkg.sv =====
// Package for the gain mixer / block limiter.
// Holds item structs, config register codes and fixed arithmetic constants.
// No dependencies.
`default_nettype none

package gmbl_pkg;

	localparam int NUM_GAINS    = 4;
	localparam int GAIN_W       = 16;
	localparam int LIMIT_W      = 15;
	localparam int SUM_W        = 19;
	localparam int PEAK_W       = 18;
	localparam int CNT_W        = 32;
	localparam int CFG_IDX_W    = 3;
	localparam int Q_SHIFT      = 15;
	localparam int QUOT_W       = 15;
	localparam int DIV_CNT_W    = $clog2(QUOT_W + 1);

	localparam logic [GAIN_W-1:0]  UNITY_GAIN    = 16'd32768;
	localparam logic [GAIN_W-1:0]  GAIN_RESET    = 16'd16384;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET   = 15'd32767;
	localparam int                 RELEASE_SHIFT = 4;
	localparam logic [PEAK_W-1:0]  PEAK_MAX      = 18'h3FFFF;

	localparam logic [CFG_IDX_W-1:0] REG_GAIN_0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_1 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_2 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_3 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT  = 3'd4;

	typedef struct packed {
		logic signed [15:0] pcm_in;
		logic [1:0]         channel_number;
		logic [4:0]         position;
		logic [3:0]         channel_mask;
		logic               frame_end;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] pcm_out;
		logic               frame_last;
		logic [17:0]        peak_before_limit;
		logic [15:0]        applied_gain;
		logic [31:0]        frame_total;
		logic [31:0]        silent_total;
		logic [31:0]        limited_total;
		logic [31:0]        clip_total;
	} out_item_t;

	typedef struct packed {
		logic [NUM_GAINS-1:0][GAIN_W-1:0] gain;
		logic [LIMIT_W-1:0]               limit;
	} cfg_regs_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/gmbl_cfg_regs.sv =====
// Configuration register file: channel gains and limit level.
// Depends on gmbl_pkg.
`default_nettype none

module gmbl_cfg_regs
	import gmbl_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 wr_en,
	input  wire logic [CFG_IDX_W-1:0] wr_index,
	input  wire logic [GAIN_W-1:0]    wr_data,
	output cfg_regs_t                 regs
);

	cfg_regs_t regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_GAINS; i++) begin
				regs_q.gain[i] <= GAIN_RESET;
			end
			regs_q.limit <= LIMIT_RESET;
		end else if (wr_en) begin
			unique case (wr_index) inside
				REG_GAIN_0, REG_GAIN_1, REG_GAIN_2, REG_GAIN_3: begin
					// gains above unity are dropped
					if (wr_data <= UNITY_GAIN) begin
						regs_q.gain[wr_index[1:0]] <= wr_data;
					end
				end
				REG_LIMIT: begin
					regs_q.limit <= wr_data[LIMIT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign regs = regs_q;

endmodule

`default_nettype wire

// ===== hw/rtl/gmbl_sum_mem.sv =====
// Per-position mix sum memory with a registered read.
// Valid bits make unwritten entries read as zero and clear the frame at once.
// Depends on gmbl_pkg.
`default_nettype none

module gmbl_sum_mem
	import gmbl_pkg::*;
#(
	parameter int DEPTH = 32,
	parameter int AW    = 5
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    rd_en,
	input  wire logic [AW-1:0]           rd_addr,
	output logic signed [SUM_W-1:0]      rd_data,
	input  wire logic                    wr_en,
	input  wire logic [AW-1:0]           wr_addr,
	input  wire logic signed [SUM_W-1:0] wr_data,
	input  wire logic                    clr_all
);

	logic signed [SUM_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0]        vld_q;
	logic signed [SUM_W-1:0] rd_word_q;
	logic                    rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_word_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (clr_all) begin
				vld_q <= '0;
			end else if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_word_q : '0;

endmodule

`default_nettype wire

// ===== hw/rtl/gmbl_divider.sv =====
// Restoring divider for the requested gain: (limit << 15) / peak.
// Caller guarantees peak > limit, so the quotient fits 15 bits. One bit per cycle.
// Depends on gmbl_pkg.
`default_nettype none

module gmbl_divider
	import gmbl_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [LIMIT_W-1:0] dividend,
	input  wire logic [PEAK_W-1:0]  divisor,
	output div_stat_t               stat,
	output logic [QUOT_W-1:0]       quotient
);

	logic [PEAK_W-1:0]    rem_q;
	logic [PEAK_W-1:0]    div_q;
	logic [QUOT_W-1:0]    quot_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [PEAK_W:0]      shifted;
	logic                 ge;

	always_comb begin
		shifted = {rem_q, 1'b0};
		ge      = shifted >= {1'b0, div_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(QUOT_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			// top half of the dividend is the limit itself, already below the divisor
			rem_q  <= {{(PEAK_W-LIMIT_W){1'b0}}, dividend};
			div_q  <= divisor;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= ge ? PEAK_W'(shifted - {1'b0, div_q}) : shifted[PEAK_W-1:0];
			quot_q <= {quot_q[QUOT_W-2:0], ge};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quot_q;

endmodule

`default_nettype wire

// ===== hw/rtl/gain_mixer_block_limiter_core.sv =====
// Gain mixer with frame peak limiter. A sample request is a sum memory read, then a
// write-back; no new request is accepted before that write-back. A frame-end request
// adds a peak scan, a divide when limiting, a gain update, a clip scan, then a read,
// multiply, saturate and output step per result; a silent frame skips to emitting zeros.
// Reset restores register defaults, unity limiter gain, zero counters and marks
// every sum entry empty through its valid bit; no clearing pass is needed.
`default_nettype none

module gain_mixer_block_limiter_core
	import gmbl_pkg::*;
#(
	parameter int CHANNELS  = 4,
	parameter int FRAME_LEN = 32
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire in_item_t             in_data,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output out_item_t                 out_data,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [GAIN_W-1:0]    cfg_data
);

	localparam int AW = (FRAME_LEN > 1) ? $clog2(FRAME_LEN) : 1;
	localparam logic [AW-1:0] LAST_IDX = AW'(FRAME_LEN - 1);
	localparam logic [3:0]    CH_MASK  = 4'((1 << CHANNELS) - 1);

	localparam logic [3:0] ST_ACC   = 4'd0;
	localparam logic [3:0] ST_PEAK  = 4'd1;
	localparam logic [3:0] ST_DIV   = 4'd2;
	localparam logic [3:0] ST_GAIN  = 4'd3;
	localparam logic [3:0] ST_CLIP  = 4'd4;
	localparam logic [3:0] ST_E_RD  = 4'd5;
	localparam logic [3:0] ST_E_MUL = 4'd6;
	localparam logic [3:0] ST_E_SAT = 4'd7;
	localparam logic [3:0] ST_E_OUT = 4'd8;

	cfg_regs_t cfg;
	div_stat_t div_stat;
	logic [QUOT_W-1:0] quot;

	logic [3:0] state_q;

	// sample path
	logic                    accept;
	logic                    keep;
	logic [6:0]              pos_ext;
	logic signed [32:0]      in_prod;
	logic                    vld_s1;
	logic                    keep_s1;
	logic                    fend_s1;
	logic                    active_s1;
	logic [AW-1:0]           addr_s1;
	logic signed [32:0]      prod_s1;
	logic signed [SUM_W-1:0] term19;

	// memory port
	logic                    mem_rd_en;
	logic [AW-1:0]           mem_rd_addr;
	logic signed [SUM_W-1:0] mem_rd_data;
	logic                    mem_wr_en;
	logic signed [SUM_W-1:0] mem_wr_data;
	logic                    mem_clr;

	// scans
	logic                    scan_go_q;
	logic [AW-1:0]           scan_idx_q;
	logic                    dat_vld_q;
	logic                    dat_last_q;
	logic                    mul_vld_q;
	logic                    mul_last_q;
	logic signed [35:0]      mul_res;
	logic signed [35:0]      prod_q;
	logic signed [20:0]      scaled;
	logic signed [15:0]      sat_val;
	logic                    clipped;
	logic [19:0]             mag;
	logic [PEAK_W-1:0]       mag_sat;
	logic [PEAK_W-1:0]       peak_next;
	logic                    over_limit;
	logic                    div_start;

	// frame state
	logic                    silent_q;
	logic [PEAK_W-1:0]       peak_q;
	logic [GAIN_W-1:0]       smooth_q;
	logic [GAIN_W-1:0]       req_q;
	logic [CNT_W-1:0]        frame_cnt_q;
	logic [CNT_W-1:0]        silent_cnt_q;
	logic [CNT_W-1:0]        limited_cnt_q;
	logic [CNT_W-1:0]        clip_cnt_q;

	// output register
	logic                    out_valid_q;
	logic signed [15:0]      out_pcm_q;
	logic                    out_last_q;
	logic                    out_accept;

	assign cfg_ready = 1'b1;

	gmbl_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.regs     (cfg)
	);

	gmbl_sum_mem #(
		.DEPTH (FRAME_LEN),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data),
		.wr_en   (mem_wr_en),
		.wr_addr (addr_s1),
		.wr_data (mem_wr_data),
		.clr_all (mem_clr)
	);

	gmbl_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (cfg.limit),
		.divisor  (peak_next),
		.stat     (div_stat),
		.quotient (quot)
	);

	// sample front end: one request in flight through the read-modify-write
	assign in_stall   = (state_q != ST_ACC) || vld_s1;
	assign accept     = in_valid && !in_stall;
	assign out_accept = out_valid_q && !out_stall;

	always_comb begin
		pos_ext = {2'b00, in_data.position};
		keep    = ({1'b0, in_data.channel_number} < 3'(CHANNELS))
			&& in_data.channel_mask[in_data.channel_number]
			&& (pos_ext < 7'(FRAME_LEN));
		in_prod = $signed(in_data.pcm_in)
			* $signed({1'b0, cfg.gain[in_data.channel_number]});
		term19      = {prod_s1[32], prod_s1[32:15]};
		mem_wr_data = mem_rd_data + term19;
		mem_wr_en   = vld_s1 && keep_s1;
	end

	always_comb begin
		mem_rd_en   = 1'b0;
		mem_rd_addr = scan_idx_q;
		if (state_q == ST_ACC) begin
			mem_rd_en   = accept;
			mem_rd_addr = pos_ext[AW-1:0];
		end else if (state_q == ST_PEAK || state_q == ST_CLIP) begin
			mem_rd_en = scan_go_q;
		end else if (state_q == ST_E_RD) begin
			mem_rd_en = 1'b1;
		end
	end

	// magnitude, peak, scaling and saturation
	always_comb begin
		mag = mem_rd_data[SUM_W-1] ? (20'd0 - {1'b1, mem_rd_data}) : {1'b0, mem_rd_data};
		mag_sat   = (mag > {2'b00, PEAK_MAX}) ? PEAK_MAX : mag[PEAK_W-1:0];
		peak_next = (mag_sat > peak_q) ? mag_sat : peak_q;
		over_limit = peak_next > {{(PEAK_W-LIMIT_W){1'b0}}, cfg.limit};
		div_start  = (state_q == ST_PEAK) && dat_vld_q && dat_last_q && over_limit;

		mul_res = mem_rd_data * $signed({1'b0, smooth_q});
		scaled  = prod_q[35:15];
		clipped = 1'b1;
		if (scaled > 21'sd32767) begin
			sat_val = 16'sh7FFF;
		end else if (scaled < -21'sd32768) begin
			sat_val = -16'sh8000;
		end else begin
			sat_val = scaled[15:0];
			clipped = 1'b0;
		end

		mem_clr = (state_q == ST_E_OUT) && out_accept && (scan_idx_q == LAST_IDX);
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			keep_s1   <= keep;
			fend_s1   <= in_data.frame_end;
			active_s1 <= |(in_data.channel_mask & CH_MASK);
			addr_s1   <= pos_ext[AW-1:0];
			prod_s1   <= in_prod;
		end
		if (dat_vld_q || state_q == ST_E_MUL) begin
			prod_q <= mul_res;
		end
		if (state_q == ST_E_SAT) begin
			out_pcm_q  <= silent_q ? 16'sd0 : sat_val;
			out_last_q <= scan_idx_q == LAST_IDX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_ACC;
			vld_s1        <= 1'b0;
			scan_go_q     <= 1'b0;
			scan_idx_q    <= '0;
			dat_vld_q     <= 1'b0;
			dat_last_q    <= 1'b0;
			mul_vld_q     <= 1'b0;
			mul_last_q    <= 1'b0;
			silent_q      <= 1'b0;
			peak_q        <= '0;
			smooth_q      <= UNITY_GAIN;
			req_q         <= UNITY_GAIN;
			frame_cnt_q   <= '0;
			silent_cnt_q  <= '0;
			limited_cnt_q <= '0;
			clip_cnt_q    <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			vld_s1     <= accept;
			dat_vld_q  <= scan_go_q;
			dat_last_q <= scan_go_q && (scan_idx_q == LAST_IDX);
			mul_vld_q  <= dat_vld_q && (state_q == ST_CLIP);
			mul_last_q <= dat_last_q && (state_q == ST_CLIP);

			if (scan_go_q) begin
				if (scan_idx_q == LAST_IDX) begin
					scan_go_q <= 1'b0;
				end else begin
					scan_idx_q <= scan_idx_q + 1'b1;
				end
			end

			unique case (state_q)
				ST_ACC: begin
					if (vld_s1 && fend_s1) begin
						frame_cnt_q <= frame_cnt_q + 32'd1;
						peak_q      <= '0;
						scan_idx_q  <= '0;
						if (!active_s1) begin
							silent_cnt_q <= silent_cnt_q + 32'd1;
							silent_q     <= 1'b1;
							state_q      <= ST_E_RD;
						end else begin
							silent_q  <= 1'b0;
							scan_go_q <= 1'b1;
							state_q   <= ST_PEAK;
						end
					end
				end
				ST_PEAK: begin
					if (dat_vld_q) begin
						peak_q <= peak_next;
						if (dat_last_q) begin
							if (over_limit) begin
								limited_cnt_q <= limited_cnt_q + 32'd1;
								state_q       <= ST_DIV;
							end else begin
								req_q   <= UNITY_GAIN;
								state_q <= ST_GAIN;
							end
						end
					end
				end
				ST_DIV: begin
					if (div_stat.done) begin
						req_q   <= {{(GAIN_W-QUOT_W){1'b0}}, quot};
						state_q <= ST_GAIN;
					end
				end
				ST_GAIN: begin
					// attack at once, release by a sixteenth of the gap to unity
					if (req_q < smooth_q) begin
						smooth_q <= req_q;
					end else begin
						smooth_q <= smooth_q + ((UNITY_GAIN - smooth_q) >> RELEASE_SHIFT);
					end
					scan_idx_q <= '0;
					scan_go_q  <= 1'b1;
					state_q    <= ST_CLIP;
				end
				ST_CLIP: begin
					if (mul_vld_q) begin
						if (clipped) begin
							clip_cnt_q <= clip_cnt_q + 32'd1;
						end
						if (mul_last_q) begin
							scan_idx_q <= '0;
							state_q    <= ST_E_RD;
						end
					end
				end
				ST_E_RD: begin
					state_q <= ST_E_MUL;
				end
				ST_E_MUL: begin
					state_q <= ST_E_SAT;
				end
				ST_E_SAT: begin
					out_valid_q <= 1'b1;
					state_q     <= ST_E_OUT;
				end
				ST_E_OUT: begin
					if (out_accept) begin
						out_valid_q <= 1'b0;
						if (scan_idx_q == LAST_IDX) begin
							state_q <= ST_ACC;
						end else begin
							scan_idx_q <= scan_idx_q + 1'b1;
							state_q    <= ST_E_RD;
						end
					end
				end
				default: begin
					state_q <= ST_ACC;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;

	always_comb begin
		out_data.pcm_out           = out_pcm_q;
		out_data.frame_last        = out_last_q;
		out_data.peak_before_limit = peak_q;
		out_data.applied_gain      = smooth_q;
		out_data.frame_total       = frame_cnt_q;
		out_data.silent_total      = silent_cnt_q;
		out_data.limited_total     = limited_cnt_q;
		out_data.clip_total        = clip_cnt_q;
	end

	a_out_only_emit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (state_q == ST_E_OUT))
		else $error("result presented outside emit phase");

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> (state_q == ST_DIV))
		else $error("divider finished outside divide phase");

	a_gain_le_unity: assert property (@(posedge clk) disable iff (!arst_n)
		smooth_q <= UNITY_GAIN)
		else $error("limiter gain above unity");

	a_last_returns_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_accept && out_last_q) |=> (state_q == ST_ACC && !out_valid_q))
		else $error("frame did not close after last result");

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for gain_mixer_block_limiter_core: directed frames for the corner
// cases, then random frames under changing gains and limit levels, checked against an
// in-bench mixer/limiter model. Depends on gmbl_pkg and the core only.

module tb_top;
	import gmbl_pkg::*;

	localparam int FRAME_LEN     = 32;
	localparam int HALF_PERIOD   = 5;
	localparam int RESET_CYCLES  = 12;
	localparam int RANDOM_ITEMS  = 480;
	localparam int SETTLE_CYCLES = 16;
	localparam int END_CYCLES    = 400;
	localparam int CYCLE_LIMIT   = 2_000_000;
	localparam int REPORT_MAX    = 10;

	localparam logic signed [15:0] PCM_MAX = 16'sh7FFF;
	localparam logic signed [15:0] PCM_MIN = 16'sh8000;

	localparam logic [CFG_IDX_W-1:0] GAIN_REG [NUM_GAINS] =
		'{REG_GAIN_0, REG_GAIN_1, REG_GAIN_2, REG_GAIN_3};
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = REG_LIMIT + 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = '1;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_stall;
	in_item_t             in_data   = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	out_item_t            out_data;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [GAIN_W-1:0]    cfg_data  = '0;

	gain_mixer_block_limiter_core #(
		.CHANNELS (NUM_GAINS),
		.FRAME_LEN(FRAME_LEN)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #HALF_PERIOD clk = ~clk;

	// mixer/limiter model state
	logic [GAIN_W-1:0]       gain_reg [NUM_GAINS];
	logic [LIMIT_W-1:0]      limit_reg;
	logic signed [SUM_W-1:0] pos_sum [FRAME_LEN];
	int unsigned             lim_gain;
	int unsigned             peak_mag;
	logic [CNT_W-1:0]        n_frames, n_silent, n_limited, n_clips;
	out_item_t               frame_out_q [$];

	int unsigned fed        = 0;
	int unsigned mismatches = 0;
	int unsigned stall_left = 0;
	int unsigned calm_left  = 0;
	int unsigned cycles     = 0;
	bit          steady     = 1'b0;

	function automatic void reset_model();
		foreach (gain_reg[c])
			gain_reg[c] = GAIN_RESET;
		limit_reg = LIMIT_RESET;
		foreach (pos_sum[k])
			pos_sum[k] = '0;
		lim_gain  = UNITY_GAIN;
		peak_mag  = 0;
		n_frames  = '0;
		n_silent  = '0;
		n_limited = '0;
		n_clips   = '0;
	endfunction

	function automatic void learn_reg(input logic [CFG_IDX_W-1:0] idx,
	                                  input logic [GAIN_W-1:0] val);
		if (idx == REG_LIMIT)
			limit_reg = val[LIMIT_W-1:0];
		else if (idx <= REG_GAIN_3 && val <= UNITY_GAIN)
			gain_reg[idx[1:0]] = val;
	endfunction

	// floor(a*b / 2^15)
	function automatic longint q15_floor(input longint a, input longint b);
		return (a * b) >>> Q_SHIFT;
	endfunction

	function automatic void mix_in(input in_item_t it);
		longint             s, v;
		int unsigned        want_gain;
		out_item_t          r;
		logic signed [15:0] pcm_k [FRAME_LEN];
		if (it.channel_mask[it.channel_number]) begin
			s = longint'(pos_sum[it.position])
				+ q15_floor(it.pcm_in, gain_reg[it.channel_number]);
			pos_sum[it.position] = s[SUM_W-1:0];
		end
		if (!it.frame_end)
			return;
		n_frames++;
		peak_mag = 0;
		if (it.channel_mask == '0) begin
			n_silent++;
			foreach (pcm_k[k])
				pcm_k[k] = '0;
		end else begin
			foreach (pos_sum[k]) begin
				v = pos_sum[k];
				if (v < 0)
					v = -v;
				if (v > PEAK_MAX)
					v = PEAK_MAX;
				if (v > peak_mag)
					peak_mag = 32'(v);
			end
			want_gain = UNITY_GAIN;
			if (peak_mag > limit_reg) begin
				want_gain = 32'((longint'(limit_reg) << Q_SHIFT) / peak_mag);
				n_limited++;
			end
			// attack at once, release slowly toward unity
			if (want_gain < lim_gain)
				lim_gain = want_gain;
			else
				lim_gain += (UNITY_GAIN - lim_gain) >> RELEASE_SHIFT;
			foreach (pos_sum[k]) begin
				v = q15_floor(pos_sum[k], lim_gain);
				if (v > PCM_MAX) begin
					n_clips++;
					v = PCM_MAX;
				end else if (v < PCM_MIN) begin
					n_clips++;
					v = PCM_MIN;
				end
				pcm_k[k] = v[15:0];
			end
		end
		foreach (pcm_k[k]) begin
			r.pcm_out           = pcm_k[k];
			r.frame_last        = (k == FRAME_LEN - 1);
			r.peak_before_limit = peak_mag[PEAK_W-1:0];
			r.applied_gain      = lim_gain[GAIN_W-1:0];
			r.frame_total       = n_frames;
			r.silent_total      = n_silent;
			r.limited_total     = n_limited;
			r.clip_total        = n_clips;
			frame_out_q.push_back(r);
		end
		foreach (pos_sum[k])
			pos_sum[k] = '0;
	endfunction

	// mostly short gaps, a few long ones
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(4, 20);
	endfunction

	function automatic logic signed [15:0] pick_pcm();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return $urandom_range(0, 1) ? PCM_MAX : PCM_MIN;
		if (r < 35)
			return 16'($urandom_range(0, 4000) - 2000);
		return 16'($urandom);
	endfunction

	function automatic in_item_t pcm_item(input logic signed [15:0] pcm, input logic [1:0] ch,
	                                      input logic [4:0] pos, input logic [3:0] mask,
	                                      input logic fend);
		in_item_t it;
		it.pcm_in         = pcm;
		it.channel_number = ch;
		it.position       = pos;
		it.channel_mask   = mask;
		it.frame_end      = fend;
		return it;
	endfunction

	task automatic push_sample(input in_item_t it);
		int unsigned gap;
		gap = steady ? 0 : pick_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_data  <= it;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		mix_in(it);
		fed++;
	endtask

	// leaves cfg_valid high so back-to-back writes follow one another without a gap
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		learn_reg(idx, val);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (frame_out_q.size() != 0)
			@(posedge clk);
		// a last request with no frame end may still be in the sum memory
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic retune(input bit extremes);
		int unsigned        c, r;
		logic [GAIN_W-1:0]  g;
		logic [LIMIT_W-1:0] lim;
		for (c = 0; c < NUM_GAINS; c++) begin
			if (!extremes && $urandom_range(0, 6) == 0)
				write_reg(GAIN_REG[c], 16'($urandom_range(UNITY_GAIN + 1, 16'hFFFF)));
			r = $urandom_range(0, 99);
			if (extremes)
				g = (c % 2) ? UNITY_GAIN : '0;
			else
				g = (r < 15) ? '0 : (r < 35) ? UNITY_GAIN : 16'($urandom_range(0, UNITY_GAIN));
			write_reg(GAIN_REG[c], g);
		end
		if ($urandom_range(0, 3) == 0)
			write_reg(3'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)), 16'($urandom));
		r = $urandom_range(0, 99);
		if (extremes)
			lim = 15'd1;
		else
			lim = (r < 15) ? 15'd1 : (r < 30) ? LIMIT_RESET : (r < 35) ? '0
				: 15'($urandom_range(1, LIMIT_RESET));
		write_reg(REG_LIMIT, {1'($urandom_range(0, 1)), lim});
		cfg_valid <= 1'b0;
	endtask

	task automatic send_random_frame();
		logic [3:0]  mask;
		int unsigned n, k;
		bit          broken, dense;
		in_item_t    it;
		mask   = ($urandom_range(0, 99) < 10) ? 4'd0 : 4'($urandom_range(1, 15));
		broken = ($urandom_range(0, 9) == 0);
		dense  = ($urandom_range(0, 7) == 0);
		n      = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 12) : $urandom_range(13, 40);
		for (k = 0; k < n; k++) begin
			it.pcm_in         = pick_pcm();
			it.channel_number = 2'($urandom_range(0, NUM_GAINS - 1));
			if (mask != '0 && $urandom_range(0, 4) != 0)
				while (!mask[it.channel_number])
					it.channel_number = 2'($urandom_range(0, NUM_GAINS - 1));
			it.position     = dense ? 5'($urandom_range(0, 3))
				: 5'($urandom_range(0, FRAME_LEN - 1));
			it.channel_mask = broken ? 4'($urandom_range(0, 15)) : mask;
			it.frame_end    = (k == n - 1);
			push_sample(it);
		end
	endtask

	task automatic test_reset_frame();
		push_sample(pcm_item(PCM_MAX, 2'd0, 5'd0, 4'hF, 1'b0));
		push_sample(pcm_item(PCM_MIN, 2'd3, 5'd31, 4'hF, 1'b0));
		push_sample(pcm_item(16'sd1234, 2'd1, 5'd5, 4'b0101, 1'b0));
		push_sample(pcm_item(-16'sd1, 2'd2, 5'd16, 4'hF, 1'b1));
	endtask

	// the frame-end mask alone decides a silent frame
	task automatic test_silent_frame();
		push_sample(pcm_item(16'sd100, 2'd0, 5'd3, 4'b0001, 1'b0));
		push_sample(pcm_item(16'sd200, 2'd1, 5'd3, 4'b0000, 1'b1));
	endtask

	task automatic test_register_writes();
		int unsigned c;
		drain_results();
		for (c = 0; c < NUM_GAINS; c++)
			write_reg(GAIN_REG[c], UNITY_GAIN);
		write_reg(REG_GAIN_0, UNITY_GAIN + 16'd1);
		write_reg(REG_GAIN_2, 16'hFFFF);
		write_reg(REG_SPARE_FIRST, 16'h0001);
		write_reg(REG_SPARE_LAST, 16'hFFFF);
		write_reg(REG_LIMIT, {1'b0, LIMIT_RESET});
		cfg_valid <= 1'b0;
	endtask

	// eight full-scale negatives reach -2^18, whose magnitude saturates
	task automatic test_peak_saturation();
		repeat (7) push_sample(pcm_item(PCM_MIN, 2'd0, 5'd7, 4'b0001, 1'b0));
		push_sample(pcm_item(PCM_MIN, 2'd0, 5'd7, 4'b0001, 1'b1));
	endtask

	task automatic test_sum_wrap();
		repeat (8) push_sample(pcm_item(PCM_MAX, 2'd1, 5'd0, 4'b0010, 1'b0));
		push_sample(pcm_item(PCM_MAX, 2'd1, 5'd0, 4'b0010, 1'b1));
	endtask

	task automatic test_zero_limit();
		drain_results();
		write_reg(REG_LIMIT, 16'h8000);   // bit 15 is dropped, level reads zero
		cfg_valid <= 1'b0;
		push_sample(pcm_item(16'sd5, 2'd2, 5'd1, 4'b0100, 1'b1));
	endtask

	task automatic test_random_frames();
		int unsigned goal, frames;
		goal   = fed + RANDOM_ITEMS;
		frames = 0;
		while (fed < goal) begin
			if (frames % 8 == 0) begin
				drain_results();
				retune(frames == 0);
			end else if ($urandom_range(0, 9) == 0) begin
				drain_results();
			end
			steady = ($urandom_range(0, 6) == 0);
			send_random_frame();
			frames++;
		end
		steady = 1'b0;
	endtask

	always @(posedge clk) begin
		out_item_t want;
		bit        bad;
		if (arst_n && out_valid && !out_stall) begin
			if (frame_out_q.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("unexpected result: pcm_out %0d", out_data.pcm_out);
			end else begin
				want = frame_out_q.pop_front();
				bad  = out_data.pcm_out !== want.pcm_out
					|| out_data.frame_last !== want.frame_last
					|| out_data.peak_before_limit !== want.peak_before_limit
					|| out_data.applied_gain !== want.applied_gain
					|| out_data.frame_total !== want.frame_total
					|| out_data.silent_total !== want.silent_total
					|| out_data.limited_total !== want.limited_total
					|| out_data.clip_total !== want.clip_total;
				if (bad) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display({"mismatch (exp/act): pcm %0d/%0d last %0b/%0b peak %0d/%0d",
							" gain %0d/%0d frames %0d/%0d silent %0d/%0d limited %0d/%0d",
							" clips %0d/%0d"},
							want.pcm_out, out_data.pcm_out,
							want.frame_last, out_data.frame_last,
							want.peak_before_limit, out_data.peak_before_limit,
							want.applied_gain, out_data.applied_gain,
							want.frame_total, out_data.frame_total,
							want.silent_total, out_data.silent_total,
							want.limited_total, out_data.limited_total,
							want.clip_total, out_data.clip_total);
				end
			end
		end
		// receiver back-pressure: stall bursts with occasional calm stretches
		if (calm_left != 0) begin
			calm_left--;
			out_stall <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
			if ($urandom_range(0, 99) < 2)
				calm_left = $urandom_range(50, 300);
			else
				stall_left = pick_gap();
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		reset_model();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_frame();
		test_silent_frame();
		test_register_writes();
		test_peak_saturation();
		test_sum_wrap();
		test_zero_limit();
		test_random_frames();
		drain_results();
		repeat (END_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
